// ===== rtl/twnr_pkg.sv =====
package twnr_pkg;

	localparam int MAX_WINDOWS_DEF = 8;
	localparam int SEC_W = 17;
	localparam int DAY_W = 20;

	localparam logic [SEC_W-1:0] SECS_PER_DAY = 17'd86400;
	localparam logic [SEC_W-1:0] LAST_SECOND  = 17'd86399;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	localparam logic [1:0] STATUS_RUN      = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_INSERTED = 2'd2;
	localparam logic [1:0] STATUS_FULL     = 2'd3;

	typedef struct packed {
		logic             mode;
		logic [SEC_W-1:0] window_from;
		logic [SEC_W-1:0] window_to;
		logic [DAY_W-1:0] query_day;
		logic [SEC_W-1:0] query_second;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             in_window;
		logic [DAY_W-1:0] next_day;
		logic [SEC_W-1:0] next_second;
		logic [DAY_W-1:0] start_day;
		logic [SEC_W-1:0] start_second;
	} out_word_t;

	// one stored window: end second, span and wrap flag
	typedef struct packed {
		logic [SEC_W-1:0] to;
		logic [SEC_W-1:0] mag;
		logic             wrap;
	} entry_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic   lt;
		entry_t entry;
		logic   found;
		entry_t acc_entry;
		logic   acc_inside;
	} chain_t;

	function automatic logic [SEC_W-1:0] sat_second(input logic [SEC_W-1:0] v);
		return (v > LAST_SECOND) ? LAST_SECOND : v;
	endfunction

endpackage

// ===== rtl/twnr_cell.sv =====
module twnr_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic                        clk,
	input  logic [twnr_pkg::SEC_W-1:0]  t,
	input  twnr_pkg::entry_t            new_entry,
	input  logic                        wr_go,
	input  logic                        valid,
	input  logic                        at_end,
	input  twnr_pkg::chain_t            chain_in,
	output twnr_pkg::chain_t            chain_out
);

	twnr_pkg::entry_t          entry_q;
	logic                      lt;
	logic                      contains;
	logic                      hit;
	logic                      sel;
	logic [twnr_pkg::SEC_W:0]  fwd_dist;

	always_comb begin
		// forward distance from t to the window end
		if (t > entry_q.to) begin
			fwd_dist = {1'b0, twnr_pkg::SECS_PER_DAY} - {1'b0, t} + {1'b0, entry_q.to};
		end else begin
			fwd_dist = {1'b0, entry_q.to} - {1'b0, t};
		end
		if (entry_q.wrap) begin
			contains = fwd_dist <= {1'b0, entry_q.mag};
		end else begin
			contains = (t <= entry_q.to) && (fwd_dist <= {1'b0, entry_q.mag});
		end
	end

	assign lt = valid && ((new_entry.to < entry_q.to) ||
		((new_entry.to == entry_q.to) && (new_entry.mag < entry_q.mag)));

	// the head cell only wins on containment
	assign hit = valid && (contains || (!HEAD && (t < entry_q.to)));
	assign sel = hit && !chain_in.found;

	always_comb begin
		chain_out.lt         = lt;
		chain_out.entry      = entry_q;
		chain_out.found      = chain_in.found || hit;
		chain_out.acc_entry  = chain_in.acc_entry | (sel ? entry_q : '0);
		chain_out.acc_inside = chain_in.acc_inside | (sel && contains);
	end

	// insert shifts the tail up by one cell
	always_ff @(posedge clk) begin
		if (wr_go && (lt || at_end)) begin
			entry_q <= chain_in.lt ? chain_in.entry : new_entry;
		end
	end

endmodule

// ===== rtl/time_window_next_run_table.sv =====
// channel  | direction | handshake             | word
// in       | input     | in_valid / in_ready   | in_word  (twnr_pkg::in_word_t)
// out      | output    | out_valid / out_ready | out_word (twnr_pkg::out_word_t)
//
// every item is first captured, then run through the cell chain
// an insert or query is resolved in a single pass along the row of MAX_WINDOWS cells
// reset clears the window count; cell contents are only read below the count
// the chain step holds while a finished word still waits on out_ready
module time_window_next_run_table #(
	parameter int MAX_WINDOWS = twnr_pkg::MAX_WINDOWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  twnr_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output twnr_pkg::out_word_t out_word
);

	localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                       state_q;
	logic [CNT_W-1:0]           count_q;
	logic                       out_valid_q;
	twnr_pkg::out_word_t        out_word_q;

	logic                       mode_q;
	twnr_pkg::entry_t           new_entry_q;
	logic [twnr_pkg::DAY_W-1:0] day_q;
	logic [twnr_pkg::SEC_W-1:0] t_q;

	twnr_pkg::chain_t           chain [MAX_WINDOWS+1];

	logic                       go;
	logic                       full;
	logic                       ins_go;
	twnr_pkg::entry_t           w;
	logic                       in_win;
	logic                       next;
	logic [twnr_pkg::DAY_W-1:0] nday;
	logic [twnr_pkg::DAY_W-1:0] sday;
	logic [twnr_pkg::SEC_W-1:0] ssec;
	twnr_pkg::out_word_t        result;

	logic [twnr_pkg::SEC_W-1:0] from_sat;
	logic [twnr_pkg::SEC_W-1:0] to_sat;
	twnr_pkg::entry_t           in_entry;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	assign go     = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign full   = count_q >= CNT_W'(MAX_WINDOWS);
	assign ins_go = go && (mode_q == twnr_pkg::MODE_INSERT) && !full;

	always_comb begin
		from_sat      = twnr_pkg::sat_second(in_word.window_from);
		to_sat        = twnr_pkg::sat_second(in_word.window_to);
		in_entry.to   = to_sat;
		in_entry.wrap = from_sat > to_sat;
		if (from_sat > to_sat) begin
			in_entry.mag = twnr_pkg::SECS_PER_DAY - from_sat + to_sat;
		end else begin
			in_entry.mag = to_sat - from_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q      <= in_word.mode;
			new_entry_q <= in_entry;
			day_q       <= in_word.query_day;
			t_q         <= twnr_pkg::sat_second(in_word.query_second);
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
		twnr_cell #(
			.HEAD(i == 0)
		) u_cell (
			.clk       (clk),
			.t         (t_q),
			.new_entry (new_entry_q),
			.wr_go     (ins_go),
			.valid     (count_q > CNT_W'(i)),
			.at_end    (count_q == CNT_W'(i)),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	always_comb begin
		// nothing later fits: fall back to the first entry
		if (chain[MAX_WINDOWS].found) begin
			w      = chain[MAX_WINDOWS].acc_entry;
			in_win = chain[MAX_WINDOWS].acc_inside;
		end else begin
			w      = chain[1].entry;
			in_win = 1'b0;
		end

		if (in_win) begin
			next = w.wrap && (t_q > w.to);
		end else if (w.wrap) begin
			next = 1'b1;
		end else begin
			next = t_q > w.to;
		end
		nday = day_q + twnr_pkg::DAY_W'(next);

		if (w.mag > w.to) begin
			sday = nday - twnr_pkg::DAY_W'(1);
			ssec = w.to + twnr_pkg::SECS_PER_DAY - w.mag;
		end else begin
			sday = nday;
			ssec = w.to - w.mag;
		end

		result = '0;
		if (mode_q == twnr_pkg::MODE_INSERT) begin
			result.status = full ? twnr_pkg::STATUS_FULL : twnr_pkg::STATUS_INSERTED;
		end else if (count_q == '0) begin
			result.status = twnr_pkg::STATUS_EMPTY;
		end else begin
			result.status       = twnr_pkg::STATUS_RUN;
			result.in_window    = in_win;
			result.next_day     = nday;
			result.next_second  = w.to;
			result.start_day    = sday;
			result.start_second = ssec;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_word_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ins_go) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_WINDOWS))
		else $error("window count past table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ins_go |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not advance window count");

	a_inside_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status != twnr_pkg::STATUS_RUN) |-> !out_word.in_window)
		else $error("in_window set on a non-run word");

	a_exec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) && out_valid_q && !out_ready |=> (state_q == ST_EXEC))
		else $error("item left execute while output stalled");
`endif

endmodule
